// ===== rtl/core/kpc_pkg.sv =====
// shared types, constants and register reset values for the key press classifier
package kpc_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int SAMPLE_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int THR_BITS = 12;
	localparam int CNT_BITS = 16;
	localparam int WIN_BITS = 8;
	localparam int ADDR_BITS = 5;
	localparam int QDEPTH = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		KEY_NONE = 2'd0,
		KEY_A    = 2'd1,
		KEY_B    = 2'd2
	} key_t;

	typedef enum logic [2:0] {
		EV_SHORT     = 3'd0,
		EV_LONG      = 3'd1,
		EV_HOLD      = 3'd2,
		EV_VERY_LONG = 3'd3,
		EV_SHORT_UP  = 3'd4,
		EV_LONG_UP   = 3'd5,
		EV_HOLD_UP   = 3'd6,
		EV_DOUBLE    = 3'd7
	} ev_kind_t;

	typedef enum logic [2:0] {
		REG_NEAR       = 3'd0,
		REG_FAR        = 3'd1,
		REG_DEBOUNCE   = 3'd2,
		REG_LONG       = 3'd3,
		REG_HOLD_EXTRA = 3'd4,
		REG_VERY_LONG  = 3'd5,
		REG_WINDOW     = 3'd6
	} reg_idx_t;

	localparam logic [THR_BITS-1:0] NEAR_RST       = 12'd100;
	localparam logic [THR_BITS-1:0] FAR_RST        = 12'd680;
	localparam logic [CNT_BITS-1:0] DEBOUNCE_RST   = 16'd2;
	localparam logic [CNT_BITS-1:0] LONG_RST       = 16'd25;
	localparam logic [CNT_BITS-1:0] HOLD_EXTRA_RST = 16'd25;
	localparam logic [CNT_BITS-1:0] VERY_LONG_RST  = 16'd175;
	localparam logic [WIN_BITS-1:0] WINDOW_RST     = 8'd11;

	typedef struct packed {
		logic [THR_BITS-1:0] near_thr;
		logic [THR_BITS-1:0] far_thr;
		logic [CNT_BITS-1:0] debounce;
		logic [CNT_BITS-1:0] long_cnt;
		logic [CNT_BITS-1:0] hold_extra;
		logic [CNT_BITS-1:0] very_long;
		logic [WIN_BITS-1:0] dbl_window;
	} kpc_cfg_t;

	typedef struct packed {
		key_t     key;
		ev_kind_t kind;
		logic     last;
	} kpc_res_t;

	// results of one tick handed to the result queue
	typedef struct packed {
		logic [1:0] count;
		kpc_res_t   res1;
		kpc_res_t   res0;
	} kpc_push_t;

endpackage

// ===== rtl/core/key_press_classifier_core.sv =====
// top level of the key press classifier: stream in, event stream out, apb registers
//   s_* carries one adc sample per poll tick (tdata bits 11:0), one transaction
//   per tick. m_* carries the key events that tick raises: zero, one or two
//   transactions, m_tlast high on the last of them; a tick with no event gives
//   no output transaction.
//   the apb port holds seven registers at byte address 4*i: near and far
//   thresholds, debounce, long, hold extra and very long counts, double window;
//   write them only while the stream is idle.
// timing
//   a sample is held in the input register, its tick is evaluated there and
//   written into a four-entry result queue, from which m_* takes its events.
//   one sample per cycle is taken while m_tready stays high and the queue has
//   room; a tick with two events needs two output transactions, and the queue
//   needs two free slots per tick.
// reset
//   arst_n clears key, counter, pending release and window state, empties the
//   queue and loads the register reset values.
// stall
//   with m_tready low, results wait in the queue; once it cannot take two more
//   the input register holds its sample and s_tready falls.
module key_press_classifier_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// slave stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [kpc_pkg::SAMPLE_TDATA_BITS-1:0] s_tdata,  // sample (11:0), zero fill above
	// master stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [7:0]                            m_tdata,  // key (1:0), zero fill above
	output logic [2:0]                            m_tuser,  // event_kind (2:0)
	output logic                                  m_tlast,
	// apb configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [kpc_pkg::ADDR_BITS-1:0]         paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);

	kpc_pkg::kpc_cfg_t  cfg;
	kpc_pkg::kpc_push_t push;
	kpc_pkg::kpc_res_t  out_res;
	logic               room;

	// register file
	kpc_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register, classification and press/release/double logic
	kpc_tick u_tick (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_sample (s_tdata[kpc_pkg::SAMPLE_BITS-1:0]),
		.room      (room),
		.push      (push)
	);

	// output queue decouples two-event ticks and receiver stalls
	kpc_res_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {6'd0, out_res.key};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

endmodule

// ===== rtl/core/kpc_cfg_regs.sv =====
// apb configuration registers of the key press classifier
module kpc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [kpc_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output kpc_pkg::kpc_cfg_t              cfg
);

	kpc_pkg::kpc_cfg_t cfg_q;
	logic              wr_en;
	logic [2:0]        idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_thr   <= kpc_pkg::NEAR_RST;
			cfg_q.far_thr    <= kpc_pkg::FAR_RST;
			cfg_q.debounce   <= kpc_pkg::DEBOUNCE_RST;
			cfg_q.long_cnt   <= kpc_pkg::LONG_RST;
			cfg_q.hold_extra <= kpc_pkg::HOLD_EXTRA_RST;
			cfg_q.very_long  <= kpc_pkg::VERY_LONG_RST;
			cfg_q.dbl_window <= kpc_pkg::WINDOW_RST;
		end else if (wr_en) begin
			case (idx)
				kpc_pkg::REG_NEAR:       cfg_q.near_thr   <= pwdata[kpc_pkg::THR_BITS-1:0];
				kpc_pkg::REG_FAR:        cfg_q.far_thr    <= pwdata[kpc_pkg::THR_BITS-1:0];
				kpc_pkg::REG_DEBOUNCE:   cfg_q.debounce   <= pwdata[kpc_pkg::CNT_BITS-1:0];
				kpc_pkg::REG_LONG:       cfg_q.long_cnt   <= pwdata[kpc_pkg::CNT_BITS-1:0];
				kpc_pkg::REG_HOLD_EXTRA: cfg_q.hold_extra <= pwdata[kpc_pkg::CNT_BITS-1:0];
				kpc_pkg::REG_VERY_LONG:  cfg_q.very_long  <= pwdata[kpc_pkg::CNT_BITS-1:0];
				kpc_pkg::REG_WINDOW:     cfg_q.dbl_window <= pwdata[kpc_pkg::WIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			kpc_pkg::REG_NEAR:       prdata = {20'd0, cfg_q.near_thr};
			kpc_pkg::REG_FAR:        prdata = {20'd0, cfg_q.far_thr};
			kpc_pkg::REG_DEBOUNCE:   prdata = {16'd0, cfg_q.debounce};
			kpc_pkg::REG_LONG:       prdata = {16'd0, cfg_q.long_cnt};
			kpc_pkg::REG_HOLD_EXTRA: prdata = {16'd0, cfg_q.hold_extra};
			kpc_pkg::REG_VERY_LONG:  prdata = {16'd0, cfg_q.very_long};
			kpc_pkg::REG_WINDOW:     prdata = {24'd0, cfg_q.dbl_window};
			default:                 prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/core/kpc_tick.sv =====
// sample input register, key/window state and the per-tick event logic
module kpc_tick (
	input  logic                            clk,
	input  logic                            arst_n,
	input  kpc_pkg::kpc_cfg_t               cfg,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [kpc_pkg::SAMPLE_BITS-1:0] in_sample,
	input  logic                            room,
	output kpc_pkg::kpc_push_t              push
);

	logic [kpc_pkg::SAMPLE_BITS-1:0] sample_s1;
	logic                            valid_s1;
	kpc_pkg::key_t                   held_q;
	logic [kpc_pkg::CNT_BITS-1:0]    ticks_q;
	kpc_pkg::key_t                   pend_q;
	logic [kpc_pkg::WIN_BITS-1:0]    win_q;

	logic                            fire;
	logic                            win_act;
	logic [kpc_pkg::WIN_BITS-1:0]    win_dec;
	logic                            tmo;
	kpc_pkg::key_t                   pend_a;
	logic [kpc_pkg::WIN_BITS-1:0]    win_a;
	kpc_pkg::key_t                   key;
	logic                            chg;
	logic [kpc_pkg::CNT_BITS:0]      hold_sum;
	logic [kpc_pkg::CNT_BITS-1:0]    tn;
	logic                            ev_valid;
	kpc_pkg::ev_kind_t               ev_kind;
	logic                            b_valid;
	kpc_pkg::key_t                   b_key;
	kpc_pkg::ev_kind_t               b_kind;
	kpc_pkg::key_t                   held_n;
	logic [kpc_pkg::CNT_BITS-1:0]    ticks_n;
	kpc_pkg::key_t                   pend_n;
	logic [kpc_pkg::WIN_BITS-1:0]    win_n;

	assign fire     = valid_s1 & room;
	assign in_ready = ~valid_s1 | room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= in_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= kpc_pkg::KEY_NONE;
			ticks_q <= '0;
			pend_q  <= kpc_pkg::KEY_NONE;
			win_q   <= '0;
		end else if (fire) begin
			held_q  <= held_n;
			ticks_q <= ticks_n;
			pend_q  <= pend_n;
			win_q   <= win_n;
		end
	end

	always_comb begin
		// double window countdown comes first
		win_act = (pend_q != kpc_pkg::KEY_NONE) && (win_q != '0);
		win_dec = win_q - 1'b1;
		tmo     = win_act && (win_dec == '0);
		pend_a  = tmo ? kpc_pkg::KEY_NONE : pend_q;
		win_a   = win_act ? win_dec : win_q;

		if (sample_s1 < cfg.near_thr) begin
			key = kpc_pkg::KEY_A;
		end else if (sample_s1 < cfg.far_thr) begin
			key = kpc_pkg::KEY_B;
		end else begin
			key = kpc_pkg::KEY_NONE;
		end

		chg      = (key == kpc_pkg::KEY_NONE) || (key != held_q);
		hold_sum = {1'b0, cfg.long_cnt} + {1'b0, cfg.hold_extra};
		tn       = ticks_q + 1'b1;
		ev_valid = 1'b0;
		ev_kind  = kpc_pkg::EV_SHORT;
		held_n   = held_q;
		ticks_n  = ticks_q;

		if (chg) begin
			held_n  = key;
			ticks_n = '0;
			if ({1'b0, ticks_q} >= hold_sum) begin
				ev_valid = 1'b1;
				ev_kind  = kpc_pkg::EV_HOLD_UP;
			end else if (ticks_q >= cfg.long_cnt) begin
				ev_valid = 1'b1;
				ev_kind  = kpc_pkg::EV_LONG_UP;
			end else if (ticks_q > cfg.debounce) begin
				ev_valid = 1'b1;
				ev_kind  = kpc_pkg::EV_SHORT_UP;
			end
			// nothing to release when no key was held
			if (held_q == kpc_pkg::KEY_NONE) begin
				ev_valid = 1'b0;
			end
		end else if (ticks_q != '1) begin
			ticks_n = tn;
			if (tn == cfg.debounce) begin
				ev_valid = 1'b1;
				ev_kind  = kpc_pkg::EV_SHORT;
			end else if (tn == cfg.long_cnt) begin
				ev_valid = 1'b1;
				ev_kind  = kpc_pkg::EV_LONG;
			end else if ({1'b0, tn} == hold_sum) begin
				ev_valid = 1'b1;
				ev_kind  = kpc_pkg::EV_HOLD;
			end else if (tn == cfg.very_long) begin
				ev_valid = 1'b1;
				ev_kind  = kpc_pkg::EV_VERY_LONG;
			end
		end

		// short release merges with or displaces the pending one
		b_valid = ev_valid;
		b_key   = held_q;
		b_kind  = ev_kind;
		pend_n  = pend_a;
		win_n   = win_a;
		if (ev_valid && (ev_kind == kpc_pkg::EV_SHORT_UP)) begin
			win_n = '0;
			if (pend_a == held_q) begin
				b_kind = kpc_pkg::EV_DOUBLE;
				pend_n = kpc_pkg::KEY_NONE;
			end else begin
				b_valid = (pend_a != kpc_pkg::KEY_NONE);
				b_key   = pend_a;
				pend_n  = held_q;
				win_n   = (cfg.dbl_window == '0) ? kpc_pkg::WIN_BITS'(1) : cfg.dbl_window;
			end
		end

		push.res0.key  = pend_q;
		push.res0.kind = kpc_pkg::EV_SHORT_UP;
		push.res0.last = ~b_valid;
		push.res1.key  = b_key;
		push.res1.kind = b_kind;
		push.res1.last = 1'b1;
		push.count     = 2'd0;
		if (fire) begin
			if (tmo && b_valid) begin
				push.count = 2'd2;
			end else if (tmo) begin
				push.count = 2'd1;
			end else if (b_valid) begin
				push.count = 2'd1;
				push.res0  = push.res1;
			end
		end
	end

`ifndef SYNTHESIS
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd2) |-> (push.res1.last && !push.res0.last))
		else $error("two results of one tick not ordered with last on the second");

	a_change_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && chg) |=> (ticks_q == '0))
		else $error("hold counter not cleared on key change");

	a_no_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |-> (push.count == 2'd0))
		else $error("results pushed without a tick");
`endif

endmodule

// ===== rtl/core/kpc_res_queue.sv =====
// small result queue taking up to two results per tick and handing out one per cycle while out_ready is high
module kpc_res_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  kpc_pkg::kpc_push_t push,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output kpc_pkg::kpc_res_t  out_res
);

	kpc_pkg::kpc_res_t                entry_q [kpc_pkg::QDEPTH];
	logic [kpc_pkg::QPTR_BITS-1:0]    wr_ptr_q;
	logic [kpc_pkg::QPTR_BITS-1:0]    rd_ptr_q;
	logic [kpc_pkg::QCNT_BITS-1:0]    count_q;
	logic [kpc_pkg::QPTR_BITS-1:0]    wr_ptr_p1;
	logic                             pop;

	assign room      = (count_q <= kpc_pkg::QCNT_BITS'(kpc_pkg::QDEPTH - 2));
	assign out_valid = (count_q != '0);
	assign out_res   = entry_q[rd_ptr_q];
	assign pop       = out_valid & out_ready;
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.res0;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_p1] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + kpc_pkg::QPTR_BITS'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + kpc_pkg::QCNT_BITS'(push.count)
				- kpc_pkg::QCNT_BITS'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0) |-> (count_q <= kpc_pkg::QCNT_BITS'(kpc_pkg::QDEPTH - 2)))
		else $error("result queue pushed without room");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= kpc_pkg::QCNT_BITS'(kpc_pkg::QDEPTH))
		else $error("result queue count out of range");
`endif

endmodule

// ===== test/key_press_classifier_core_test.sv =====
// testbench for the key press classifier: directed table, random key presses, extreme registers
`timescale 1ns / 1ps

module key_press_classifier_core_test;
	import kpc_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PHASE_TICKS    = 200;
	localparam int RANDOM_PHASES  = 8;
	localparam int DIR_ROWS       = 25;
	localparam int PRINT_CAP      = 40;

	localparam kpc_res_t NO_EV = '{KEY_NONE, EV_SHORT, 1'b0};

	typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_SLOW} rx_mode_t;

	// one directed sample; typed rows carry their events, the rest use the predictor
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] smp;
		logic                   retune;
		logic                   typed;
		logic [1:0]             n;
		kpc_res_t               ev0;
		kpc_res_t               ev1;
	} tick_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [SAMPLE_TDATA_BITS-1:0] s_tdata;   // sample (11:0), zero fill above
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [7:0]                   m_tdata;   // key (1:0), zero fill above
	logic [2:0]                   m_tuser;   // event_kind (2:0)
	logic                         m_tlast;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [ADDR_BITS-1:0]         paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	key_press_classifier_core dut (.*);

	// classifier mirror: register copy and tick state
	kpc_cfg_t        cfg;
	key_t            held;
	logic [15:0]     held_ticks;
	key_t            pend;
	logic [7:0]      win_left;
	kpc_res_t        tick_ev [2];

	kpc_res_t        awaited_events [$];
	int              mismatches = 0;
	int              sent_total = 0;
	int              burst_left = 0;
	int              idle_cycles = 0;
	rx_mode_t        rx_mode = RX_FREE;
	int              rx_left = 0;
	tick_row_t       dir_rows [DIR_ROWS];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	// event routing; short ups get double detection and pending release bookkeeping
	function automatic void raise_event(input key_t k, input ev_kind_t kind, inout int n);
		if (k == KEY_NONE)
			return;
		if (kind != EV_SHORT_UP) begin
			tick_ev[n] = '{k, kind, 1'b0};
			n++;
			return;
		end
		win_left = 8'd0;
		if (pend == k) begin
			tick_ev[n] = '{k, EV_DOUBLE, 1'b0};
			n++;
			pend = KEY_NONE;
		end else begin
			if (pend != KEY_NONE) begin
				tick_ev[n] = '{pend, EV_SHORT_UP, 1'b0};
				n++;
			end
			pend = k;
			win_left = (cfg.dbl_window == 8'd0) ? 8'd1 : cfg.dbl_window;
		end
	endfunction

	// advances the mirror by one poll tick, returns the number of events raised
	function automatic int advance_classifier(input logic [SAMPLE_BITS-1:0] smp);
		int   n;
		int   hold_sum;
		int   was_ticks;
		key_t now_key;
		key_t was_key;
		n = 0;
		hold_sum = int'(cfg.long_cnt) + int'(cfg.hold_extra);
		// double window runs out before the sample is looked at
		if (pend != KEY_NONE && win_left != 8'd0) begin
			win_left--;
			if (win_left == 8'd0) begin
				tick_ev[n] = '{pend, EV_SHORT_UP, 1'b0};
				n++;
				pend = KEY_NONE;
			end
		end
		if (smp < cfg.near_thr)
			now_key = KEY_A;
		else if (smp < cfg.far_thr)
			now_key = KEY_B;
		else
			now_key = KEY_NONE;
		if (now_key == KEY_NONE || now_key != held) begin
			was_key = held;
			was_ticks = int'(held_ticks);
			held = now_key;
			held_ticks = 16'd0;
			if (was_ticks >= hold_sum)
				raise_event(was_key, EV_HOLD_UP, n);
			else if (was_ticks >= int'(cfg.long_cnt))
				raise_event(was_key, EV_LONG_UP, n);
			else if (was_ticks > int'(cfg.debounce))
				raise_event(was_key, EV_SHORT_UP, n);
		end else if (held_ticks != 16'hFFFF) begin
			// counter saturates, and a saturated tick raises nothing
			held_ticks++;
			if (held_ticks == cfg.debounce)
				raise_event(held, EV_SHORT, n);
			else if (held_ticks == cfg.long_cnt)
				raise_event(held, EV_LONG, n);
			else if (int'(held_ticks) == hold_sum)
				raise_event(held, EV_HOLD, n);
			else if (held_ticks == cfg.very_long)
				raise_event(held, EV_VERY_LONG, n);
		end
		if (n > 0)
			tick_ev[n-1].last = 1'b1;
		return n;
	endfunction

	function automatic tick_row_t free_row(input logic [SAMPLE_BITS-1:0] smp);
		return '{smp, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV};
	endfunction

	// a sample that reads as the wanted key under the current thresholds
	function automatic logic [SAMPLE_BITS-1:0] pick_sample(input key_t k);
		int lo;
		case (k)
			KEY_A: begin
				if (cfg.near_thr != 0)
					return SAMPLE_BITS'($urandom_range(0, int'(cfg.near_thr) - 1));
			end
			KEY_B: begin
				if (cfg.far_thr > cfg.near_thr)
					return SAMPLE_BITS'($urandom_range(int'(cfg.near_thr),
						int'(cfg.far_thr) - 1));
			end
			default: begin
				lo = (cfg.far_thr > cfg.near_thr) ? int'(cfg.far_thr) : int'(cfg.near_thr);
				return SAMPLE_BITS'($urandom_range(lo, 4095));
			end
		endcase
		return SAMPLE_BITS'($urandom_range(0, 4095));
	endfunction

	// press lengths cluster around the event counts
	function automatic int press_length();
		int base;
		int len;
		case ($urandom_range(0, 5))
			0: base = int'(cfg.debounce);
			1: base = int'(cfg.long_cnt);
			2: base = int'(cfg.long_cnt) + int'(cfg.hold_extra);
			3: base = int'(cfg.very_long);
			default: base = $urandom_range(1, 12);
		endcase
		len = base + int'($urandom_range(0, 2)) - 1;
		if (len < 1)
			len = 1;
		if (len > 400)
			len = $urandom_range(1, 12);
		return len;
	endfunction

	function automatic kpc_cfg_t pick_settings(input int ph);
		kpc_cfg_t c;
		c.near_thr   = THR_BITS'($urandom_range(1, 2000));
		c.far_thr    = THR_BITS'($urandom_range(int'(c.near_thr) + 1, 4095));
		c.debounce   = CNT_BITS'($urandom_range(0, 4));
		c.long_cnt   = c.debounce + CNT_BITS'($urandom_range(0, 8));
		c.hold_extra = CNT_BITS'($urandom_range(0, 6));
		c.very_long  = CNT_BITS'($urandom_range(0, 30));
		c.dbl_window = WIN_BITS'($urandom_range(0, 16));
		case (ph)
			0: c = '{NEAR_RST, FAR_RST, DEBOUNCE_RST, LONG_RST, HOLD_EXTRA_RST,
				VERY_LONG_RST, WINDOW_RST};
			// key A unreachable, empty window register
			1: begin
				c.near_thr = '0;
				c.far_thr = '1;
				c.dbl_window = '0;
			end
			// key B unreachable, widest window
			2: begin
				c.near_thr = '1;
				c.far_thr = '1;
				c.dbl_window = '1;
			end
			// crossed thresholds, one-tick window
			3: begin
				c.near_thr = 12'd3000;
				c.far_thr = 12'd1000;
				c.dbl_window = 8'd1;
			end
			// debounce past long
			4: begin
				c.debounce = 16'd9;
				c.long_cnt = 16'd4;
			end
			default: ;
		endcase
		return c;
	endfunction

	// one apb write: setup cycle then access cycle, psel left high for the next one
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_NEAR:       cfg.near_thr = val[THR_BITS-1:0];
			REG_FAR:        cfg.far_thr = val[THR_BITS-1:0];
			REG_DEBOUNCE:   cfg.debounce = val[CNT_BITS-1:0];
			REG_LONG:       cfg.long_cnt = val[CNT_BITS-1:0];
			REG_HOLD_EXTRA: cfg.hold_extra = val[CNT_BITS-1:0];
			REG_VERY_LONG:  cfg.very_long = val[CNT_BITS-1:0];
			REG_WINDOW:     cfg.dbl_window = val[WIN_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input kpc_cfg_t c);
		write_reg(REG_NEAR, 32'(c.near_thr));
		write_reg(REG_FAR, 32'(c.far_thr));
		write_reg(REG_DEBOUNCE, 32'(c.debounce));
		write_reg(REG_LONG, 32'(c.long_cnt));
		write_reg(REG_HOLD_EXTRA, 32'(c.hold_extra));
		write_reg(REG_VERY_LONG, 32'(c.very_long));
		write_reg(REG_WINDOW, 32'(c.dbl_window));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// stop sending, let every event drain and any silent tick leave the pipeline
	task automatic settle();
		s_tvalid <= 1'b0;
		while (awaited_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one sample transaction in bursts with random gaps; valid stays high between ticks of a burst
	task automatic send_tick(input tick_row_t r);
		int n;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= SAMPLE_TDATA_BITS'(r.smp);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_total++;
		n = advance_classifier(r.smp);
		if (r.typed) begin
			if (r.n > 0)
				awaited_events.push_back(r.ev0);
			if (r.n > 1)
				awaited_events.push_back(r.ev1);
		end else begin
			for (int i = 0; i < n; i++)
				awaited_events.push_back(tick_ev[i]);
		end
	endtask

	// receiver: free running, light or heavy random stalls, or long slow stretches
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 160);
		end
		rx_left--;
		case (rx_mode)
			RX_FREE:  m_tready <= 1'b1;
			RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY: m_tready <= ($urandom_range(0, 1) == 1);
			default:  m_tready <= ((rx_left % 32) < 4);
		endcase
	end

	// result check against the oldest awaited event
	always @(posedge clk) begin : check_events
		kpc_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_events.size() == 0) begin
				report_mismatch($sformatf("event key %0d kind %0d with none awaited",
					m_tdata, m_tuser));
			end else begin
				want = awaited_events.pop_front();
				if (m_tdata !== {6'b0, want.key} || m_tuser !== want.kind ||
					m_tlast !== want.last)
					report_mismatch($sformatf(
						"key %0d kind %0d last %0b, awaited key %0d kind %0d last %0b",
						m_tdata, m_tuser, m_tlast, want.key, want.kind, want.last));
			end
		end
	end

	// watchdog: cycles without any stream transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		key_t k;
		int   len;
		int   phase_end;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		cfg = '{NEAR_RST, FAR_RST, DEBOUNCE_RST, LONG_RST, HOLD_EXTRA_RST,
			VERY_LONG_RST, WINDOW_RST};
		held = KEY_NONE;
		held_ticks = '0;
		pend = KEY_NONE;
		win_left = '0;

		// reset values first, then short counts (debounce 1, long 3, hold 4,
		// very long 6, window 5) for double, window timeout, press and release kinds
		dir_rows = '{
			'{12'd4095, 1'b0, 1'b1, 2'd0, NO_EV, NO_EV},
			'{12'd100,  1'b0, 1'b1, 2'd0, NO_EV, NO_EV},
			'{12'd99,   1'b0, 1'b1, 2'd0, NO_EV, NO_EV},
			'{12'd0,    1'b0, 1'b1, 2'd0, NO_EV, NO_EV},
			'{12'd0,    1'b0, 1'b1, 2'd1, '{KEY_A, EV_SHORT, 1'b1}, NO_EV},
			'{12'd680,  1'b1, 1'b0, 2'd0, NO_EV, NO_EV},   // short release pends
			'{12'd0,    1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
			'{12'd0,    1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
			'{12'd0,    1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
			'{12'd679,  1'b0, 1'b0, 2'd0, NO_EV, NO_EV},   // key change makes a double
			'{12'd679,  1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
			'{12'd679,  1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
			'{12'd4095, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
			'{12'd679,  1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
			'{12'd679,  1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
			'{12'd679,  1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
			'{12'd679,  1'b0, 1'b0, 2'd0, NO_EV, NO_EV},   // long
			'{12'd679,  1'b0, 1'b0, 2'd0, NO_EV, NO_EV},   // window timeout plus hold
			'{12'd679,  1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
			'{12'd679,  1'b0, 1'b0, 2'd0, NO_EV, NO_EV},   // very long
			'{12'd99,   1'b0, 1'b0, 2'd0, NO_EV, NO_EV},   // hold up on key change
			'{12'd0,    1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
			'{12'd0,    1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
			'{12'd0,    1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
			'{12'd4095, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV}    // long up
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].retune) begin
				settle();
				load_settings('{NEAR_RST, FAR_RST, 16'd1, 16'd3, 16'd1, 16'd6, 8'd5});
			end
			send_tick(dir_rows[i]);
		end

		// random phases: mostly well-formed presses and releases, some noise
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			load_settings(pick_settings(ph));
			phase_end = sent_total + PHASE_TICKS;
			while (sent_total < phase_end) begin
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 3))
						send_tick(free_row(SAMPLE_BITS'($urandom_range(0, 4095))));
				end else begin
					k = ($urandom_range(0, 1) == 0) ? KEY_A : KEY_B;
					len = press_length();
					repeat (len) send_tick(free_row(pick_sample(k)));
					// mostly a release follows; otherwise the next press, of either key, follows with no release between
					if ($urandom_range(0, 3) != 0) begin
						len = $urandom_range(1, int'(cfg.dbl_window) + 3);
						repeat (len) send_tick(free_row(pick_sample(KEY_NONE)));
					end
				end
			end
		end

		// extreme registers: widest thresholds and window, long counts out of reach
		settle();
		load_settings('{12'hFFF, 12'hFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF});
		repeat (6) begin
			repeat (4) send_tick(free_row(pick_sample(KEY_A)));
			repeat (3) send_tick(free_row(pick_sample(KEY_NONE)));
		end

		s_tvalid <= 1'b0;
		while (awaited_events.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
